@@ sv/ppid_pkg.sv @@
package ppid_pkg;

  localparam int DATA_WIDTH = 16;
  localparam int FRAC_BITS  = 8;
  localparam int SUM_WIDTH  = 32;

  localparam int GAIN_W  = 16;
  localparam int BOUND_W = 31;
  localparam int THR_W   = 16;
  localparam int ERR_W   = DATA_WIDTH + 1;
  localparam int DIFF_W  = DATA_WIDTH + 2;
  localparam int P_W     = GAIN_W + ERR_W;
  localparam int I_W     = GAIN_W + SUM_WIDTH;
  localparam int D_W     = GAIN_W + DIFF_W;
  localparam int ACC_W   = I_W + 2;

  localparam int CFG_W     = 31;
  localparam int CFG_IDX_W = 3;

  localparam logic [CFG_IDX_W-1:0] REG_GAIN_P     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_I     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_D     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_INT_BOUND  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_OUT_FLOOR  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_OUT_CEIL   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_SEP_ENABLE = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SEP_THRESH = 3'd7;

  typedef struct packed {
    logic signed [GAIN_W-1:0]     gain_p;
    logic signed [GAIN_W-1:0]     gain_i;
    logic signed [GAIN_W-1:0]     gain_d;
    logic        [BOUND_W-1:0]    integral_bound;
    logic signed [DATA_WIDTH-1:0] output_floor;
    logic signed [DATA_WIDTH-1:0] output_ceiling;
    logic                         sep_enable;
    logic        [THR_W-1:0]      sep_threshold;
  } cfg_t;

endpackage

@@ sv/ppid_err.sv @@
module ppid_err (
  input  logic                                    clk,
  input  logic                                    rst,
  input  ppid_pkg::cfg_t                          cfg,
  input  logic                                    in_valid,
  output logic                                    in_ready,
  input  logic signed [ppid_pkg::DATA_WIDTH-1:0]  setpoint,
  input  logic signed [ppid_pkg::DATA_WIDTH-1:0]  measured,
  output logic                                    out_valid,
  input  logic                                    out_ready,
  output logic signed [ppid_pkg::ERR_W-1:0]       err,
  output logic signed [ppid_pkg::DIFF_W-1:0]      diff,
  output logic signed [ppid_pkg::SUM_WIDTH-1:0]   sum,
  output logic                                    int_on
);

  localparam int SW = ppid_pkg::SUM_WIDTH;
  localparam int EW = ppid_pkg::ERR_W;
  localparam int DW = ppid_pkg::DIFF_W;

  logic signed [SW-1:0] error_sum;
  logic signed [EW-1:0] previous_error;

  logic signed [EW-1:0] err_c;
  logic        [EW-1:0] mag_c;
  logic                 add_ok;
  logic                 int_on_c;
  logic signed [SW:0]   err_add;
  logic signed [SW:0]   s_raw;
  logic signed [SW:0]   s_clamp;
  logic signed [SW:0]   bnd_pos;
  logic signed [SW:0]   bnd_neg;
  logic signed [SW-1:0] sum_next;
  logic signed [DW-1:0] diff_c;
  logic                 load;

  assign in_ready = !out_valid || out_ready;
  assign load     = in_valid && in_ready;

  always_comb begin
    err_c    = {setpoint[ppid_pkg::DATA_WIDTH-1], setpoint}
             - {measured[ppid_pkg::DATA_WIDTH-1], measured};
    mag_c    = err_c[EW-1] ? (~err_c + 1'b1) : err_c;
    add_ok   = !cfg.sep_enable
             || (mag_c <= {{(EW-ppid_pkg::THR_W){1'b0}}, cfg.sep_threshold});
    // integration only for a strictly positive gain
    int_on_c = !cfg.gain_i[ppid_pkg::GAIN_W-1] && (cfg.gain_i != '0);
    err_add  = add_ok ? {{(SW+1-EW){err_c[EW-1]}}, err_c} : '0;
    s_raw    = {error_sum[SW-1], error_sum} + err_add;
    bnd_pos  = {{(SW+1-ppid_pkg::BOUND_W){1'b0}}, cfg.integral_bound};
    bnd_neg  = -bnd_pos;
    s_clamp  = s_raw;
    if (s_clamp > bnd_pos) begin
      s_clamp = bnd_pos;
    end
    if (s_clamp < bnd_neg) begin
      s_clamp = bnd_neg;
    end
    sum_next = int_on_c ? s_clamp[SW-1:0] : error_sum;
    diff_c   = {err_c[EW-1], err_c}
             - {previous_error[EW-1], previous_error};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid      <= 1'b0;
      error_sum      <= '0;
      previous_error <= '0;
    end else begin
      if (load) begin
        error_sum      <= sum_next;
        previous_error <= err_c;
        out_valid      <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      err    <= err_c;
      diff   <= diff_c;
      sum    <= sum_next;
      int_on <= int_on_c;
    end
  end

endmodule

@@ sv/ppid_mul.sv @@
module ppid_mul (
  input  logic                                   clk,
  input  logic                                   rst,
  input  ppid_pkg::cfg_t                         cfg,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  logic signed [ppid_pkg::ERR_W-1:0]      err,
  input  logic signed [ppid_pkg::DIFF_W-1:0]     diff,
  input  logic signed [ppid_pkg::SUM_WIDTH-1:0]  sum,
  input  logic                                   int_on,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic signed [ppid_pkg::P_W-1:0]        prod_p,
  output logic signed [ppid_pkg::I_W-1:0]        prod_i,
  output logic signed [ppid_pkg::D_W-1:0]        prod_d
);

  localparam int GW = ppid_pkg::GAIN_W;
  localparam int PW = ppid_pkg::P_W;
  localparam int IW = ppid_pkg::I_W;
  localparam int DW = ppid_pkg::D_W;
  localparam int EW = ppid_pkg::ERR_W;
  localparam int SW = ppid_pkg::SUM_WIDTH;
  localparam int FW = ppid_pkg::DIFF_W;

  logic signed [PW-1:0] gp_x, e_x, p_c;
  logic signed [IW-1:0] gi_x, s_x, i_c;
  logic signed [DW-1:0] gd_x, d_x, d_c;
  logic                 load;

  assign in_ready = !out_valid || out_ready;
  assign load     = in_valid && in_ready;

  always_comb begin
    gp_x = {{(PW-GW){cfg.gain_p[GW-1]}}, cfg.gain_p};
    e_x  = {{(PW-EW){err[EW-1]}}, err};
    gi_x = {{(IW-GW){cfg.gain_i[GW-1]}}, cfg.gain_i};
    s_x  = {{(IW-SW){sum[SW-1]}}, sum};
    gd_x = {{(DW-GW){cfg.gain_d[GW-1]}}, cfg.gain_d};
    d_x  = {{(DW-FW){diff[FW-1]}}, diff};
    p_c  = gp_x * e_x;
    i_c  = gi_x * s_x;
    d_c  = gd_x * d_x;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      prod_p <= p_c;
      prod_i <= int_on ? i_c : '0;
      prod_d <= d_c;
    end
  end

endmodule

@@ sv/ppid_out.sv @@
module ppid_out (
  input  logic                                   clk,
  input  logic                                   rst,
  input  ppid_pkg::cfg_t                         cfg,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  logic signed [ppid_pkg::P_W-1:0]        prod_p,
  input  logic signed [ppid_pkg::I_W-1:0]        prod_i,
  input  logic signed [ppid_pkg::D_W-1:0]        prod_d,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic signed [ppid_pkg::DATA_WIDTH-1:0] drive
);

  localparam int AW = ppid_pkg::ACC_W;
  localparam int PW = ppid_pkg::P_W;
  localparam int IW = ppid_pkg::I_W;
  localparam int DW = ppid_pkg::D_W;
  localparam int OW = ppid_pkg::DATA_WIDTH;

  logic signed [AW-1:0] acc, shd, ceil_x, floor_x, y;
  logic                 load;

  assign in_ready = !out_valid || out_ready;
  assign load     = in_valid && in_ready;

  always_comb begin
    acc = {{(AW-PW){prod_p[PW-1]}}, prod_p}
        + {{(AW-IW){prod_i[IW-1]}}, prod_i}
        + {{(AW-DW){prod_d[DW-1]}}, prod_d};
    // arithmetic shift, rounds toward minus infinity
    shd     = acc >>> ppid_pkg::FRAC_BITS;
    ceil_x  = {{(AW-OW){cfg.output_ceiling[OW-1]}}, cfg.output_ceiling};
    floor_x = {{(AW-OW){cfg.output_floor[OW-1]}}, cfg.output_floor};
    y       = shd;
    if (y > ceil_x) begin
      y = ceil_x;
    end
    // floor last so it wins when the limits cross
    if (y < floor_x) begin
      y = floor_x;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      drive <= y[OW-1:0];
    end
  end

endmodule

@@ sv/positional_pid_controller.sv @@
// positional pid controller, one sample per request
//
// input channel: in_valid/in_ready carry setpoint and measured (signed).
// output channel: out_valid/out_ready carry drive, the clamped output
// p*e + i*sum + d*(e - e_prev), gains in q8.8, arithmetic shift right by 8.
// config port: cfg_wen writes cfg_data into register cfg_index in the same
// edge; write only while no request is in flight.
//
// pipeline: input register, error/integral stage, multiplier stage, sum and
// clamp stage feeding the output register. throughput is one request per
// cycle while the receiver does not stall; the integral update is a
// combinational add and clamp on the registered error_sum loop.
//
// each stage holds its data while the next one is full, so a stalled
// receiver backs the pipeline up; in_ready drops only once all four stages
// hold data. nothing is lost or repeated.
//
// reset clears the integral, the previous error, all stage valid bits and
// sets the registers to their defaults (gains 0, full output range).
module positional_pid_controller (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   cfg_wen,
  input  logic [ppid_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [ppid_pkg::CFG_W-1:0]             cfg_data,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  logic signed [ppid_pkg::DATA_WIDTH-1:0] setpoint,
  input  logic signed [ppid_pkg::DATA_WIDTH-1:0] measured,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic signed [ppid_pkg::DATA_WIDTH-1:0] drive
);

  localparam int OW = ppid_pkg::DATA_WIDTH;

  ppid_pkg::cfg_t cfg;

  // input register
  logic                 in_v;
  logic signed [OW-1:0] sp_q;
  logic signed [OW-1:0] ms_q;

  // stage links
  logic                                  err_in_ready;
  logic                                  err_valid, mul_in_ready;
  logic signed [ppid_pkg::ERR_W-1:0]     err;
  logic signed [ppid_pkg::DIFF_W-1:0]    diff;
  logic signed [ppid_pkg::SUM_WIDTH-1:0] sum;
  logic                                  int_on;
  logic                                  mul_valid, out_in_ready;
  logic signed [ppid_pkg::P_W-1:0]       prod_p;
  logic signed [ppid_pkg::I_W-1:0]       prod_i;
  logic signed [ppid_pkg::D_W-1:0]       prod_d;

  // register file, fields are truncated to their widths
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.gain_p         <= '0;
      cfg.gain_i         <= '0;
      cfg.gain_d         <= '0;
      cfg.integral_bound <= '0;
      cfg.output_floor   <= {1'b1, {(OW-1){1'b0}}};
      cfg.output_ceiling <= {1'b0, {(OW-1){1'b1}}};
      cfg.sep_enable     <= 1'b0;
      cfg.sep_threshold  <= '0;
    end else if (cfg_wen) begin
      case (cfg_index)
        ppid_pkg::REG_GAIN_P:     cfg.gain_p         <= cfg_data[ppid_pkg::GAIN_W-1:0];
        ppid_pkg::REG_GAIN_I:     cfg.gain_i         <= cfg_data[ppid_pkg::GAIN_W-1:0];
        ppid_pkg::REG_GAIN_D:     cfg.gain_d         <= cfg_data[ppid_pkg::GAIN_W-1:0];
        ppid_pkg::REG_INT_BOUND:  cfg.integral_bound <= cfg_data[ppid_pkg::BOUND_W-1:0];
        ppid_pkg::REG_OUT_FLOOR:  cfg.output_floor   <= cfg_data[OW-1:0];
        ppid_pkg::REG_OUT_CEIL:   cfg.output_ceiling <= cfg_data[OW-1:0];
        ppid_pkg::REG_SEP_ENABLE: cfg.sep_enable     <= cfg_data[0];
        ppid_pkg::REG_SEP_THRESH: cfg.sep_threshold  <= cfg_data[ppid_pkg::THR_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // input register takes a request whenever the error stage can drain it
  assign in_ready = !in_v || err_in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_v <= 1'b0;
    end else if (in_valid && in_ready) begin
      in_v <= 1'b1;
    end else if (err_in_ready) begin
      in_v <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      sp_q <= setpoint;
      ms_q <= measured;
    end
  end

  // error, derivative difference and integral update
  ppid_err u_err (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (in_v),
    .in_ready  (err_in_ready),
    .setpoint  (sp_q),
    .measured  (ms_q),
    .out_valid (err_valid),
    .out_ready (mul_in_ready),
    .err       (err),
    .diff      (diff),
    .sum       (sum),
    .int_on    (int_on)
  );

  // the three gain products
  ppid_mul u_mul (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (err_valid),
    .in_ready  (mul_in_ready),
    .err       (err),
    .diff      (diff),
    .sum       (sum),
    .int_on    (int_on),
    .out_valid (mul_valid),
    .out_ready (out_in_ready),
    .prod_p    (prod_p),
    .prod_i    (prod_i),
    .prod_d    (prod_d)
  );

  // sum, scale, clamp, output register
  ppid_out u_out (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (mul_valid),
    .in_ready  (out_in_ready),
    .prod_p    (prod_p),
    .prod_i    (prod_i),
    .prod_d    (prod_d),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .drive     (drive)
  );

endmodule

@@ sv/ppid_chk.sv @@
module ppid_chk (
  input logic                                   clk,
  input logic                                   rst,
  input logic                                   in_valid,
  input logic                                   in_ready,
  input logic                                   out_valid,
  input logic                                   out_ready,
  input logic signed [ppid_pkg::DATA_WIDTH-1:0] drive
);

  logic in_acc;
  assign in_acc = in_valid && in_ready;

  // pipeline empty right after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid && in_ready)
    else $error("pipeline not empty after reset");

  // a stalled result holds
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(drive))
    else $error("stalled result changed");

  // with an empty output register no stage can be blocked
  a_ready_free: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input stalled with empty output");

  // a drain with no requests taken and out_ready held high empties the pipeline
  a_drain: assert property (@(posedge clk) disable iff (rst)
    (!$past(in_acc, 1) && !$past(in_acc, 2) && !$past(in_acc, 3) && !$past(in_acc, 4)
     && $past(out_ready, 1) && $past(out_ready, 2) && $past(out_ready, 3)
     && $past(out_ready, 4)) |-> !out_valid)
    else $error("result without a request");

endmodule

bind positional_pid_controller ppid_chk u_ppid_chk (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .drive     (drive)
);
